// File: rtl/core/skpl_pkg.sv
// Shared types, codes and helpers for the sorted key priority list.
package skpl_pkg;

   localparam int CAPACITY_DEFAULT = 16;
   localparam int KEY_W = 32;
   localparam int ITEM_W = 32;
   localparam int OP_W = 3;
   localparam int STATUS_W = 2;
   localparam int COUNT_OUT_W = 5;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);
   localparam int QFILL_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [OP_W-1:0] OP_PREPEND  = 3'd0;
   localparam logic [OP_W-1:0] OP_APPEND   = 3'd1;
   localparam logic [OP_W-1:0] OP_REM_HEAD = 3'd2;
   localparam logic [OP_W-1:0] OP_INSERT   = 3'd3;
   localparam logic [OP_W-1:0] OP_REM_KEY  = 3'd4;

   localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
   localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

   typedef enum logic [2:0] {
      CMD_PREPEND,
      CMD_APPEND,
      CMD_REM_HEAD,
      CMD_INSERT,
      CMD_REM_KEY,
      CMD_NOP
   } cmd_type;

   typedef struct packed {
      cmd_type             cmd;
      logic [KEY_W-1:0]    key;
      logic [ITEM_W-1:0]   item;
   } req_type;

   function automatic logic key_less(input logic [KEY_W-1:0] a, input logic [KEY_W-1:0] b);
      return $signed(a) < $signed(b);
   endfunction

endpackage

// File: rtl/core/skpl_front.sv
// Front end: accepts requests and decodes the operation code into a command.
module skpl_front
   import skpl_pkg::*;
(
   input  logic                    start,
   input  logic [OP_W-1:0]         req_op,
   input  logic [KEY_W-1:0]        req_key_in,
   input  logic [ITEM_W-1:0]       req_item_in,
   input  logic                    q_full,
   output logic                    busy,
   output logic                    push,
   output req_type                 push_req
);

   cmd_type cmd;

   always_comb begin
      unique case (req_op)
         OP_PREPEND:  cmd = CMD_PREPEND;
         OP_APPEND:   cmd = CMD_APPEND;
         OP_REM_HEAD: cmd = CMD_REM_HEAD;
         OP_INSERT:   cmd = CMD_INSERT;
         OP_REM_KEY:  cmd = CMD_REM_KEY;
         default:     cmd = CMD_NOP;
      endcase
   end

   assign busy = q_full;
   assign push = start & ~q_full;
   assign push_req = '{cmd: cmd, key: req_key_in, item: req_item_in};

endmodule

// File: rtl/core/skpl_queue.sv
// Short request queue that decouples the front end from the list engine.
module skpl_queue
   import skpl_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  req_type   push_req,
   input  logic      pop,
   output logic      q_full,
   output logic      q_valid,
   output req_type   q_req
);

   req_type              slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [QFILL_W-1:0]   fill_ff, fill_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      unique case ({push, pop})
         2'b10:   fill_in = fill_ff + QFILL_W'(1);
         2'b01:   fill_in = fill_ff - QFILL_W'(1);
         default: fill_in = fill_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_req;
      end
   end

   assign q_full  = (fill_ff == QFILL_W'(QUEUE_DEPTH));
   assign q_valid = (fill_ff != '0);
   assign q_req   = slot_ff[rd_ptr_ff];

endmodule

// File: rtl/core/skpl_back.sv
// List engine: holds the sorted entries in a memory and carries out each command.
module skpl_back
   import skpl_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEFAULT
)
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_we,
   input  logic [KEY_W-1:0]         csr_wdata,
   input  logic                     q_valid,
   input  req_type                  q_req,
   output logic                     pop,
   output logic                     rsp_valid,
   output logic [STATUS_W-1:0]      rsp_status,
   output logic [KEY_W-1:0]         rsp_key_out,
   output logic [ITEM_W-1:0]        rsp_item_out,
   output logic [COUNT_OUT_W-1:0]   rsp_count_out
);

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int EW = KEY_W + ITEM_W;

   typedef enum logic [6:0] {
      S_IDLE = 7'b0000001,
      S_HEAD = 7'b0000010,
      S_SCAN = 7'b0000100,
      S_UP   = 7'b0001000,
      S_PUT  = 7'b0010000,
      S_DN   = 7'b0100000,
      S_REM  = 7'b1000000
   } state_type;

   logic [EW-1:0]   entry_mem [CAPACITY];
   logic [EW-1:0]   rd_data_ff;
   logic [AW-1:0]   rd_addr;
   logic            wr_en;
   logic [AW-1:0]   wr_addr;
   logic [EW-1:0]   wr_data;

   state_type               state_ff, state_in;
   logic [CW-1:0]           count_ff, count_in;
   logic [CW-1:0]           pos_ff, pos_in;
   logic [AW-1:0]           idx_ff, idx_in;
   cmd_type                 cmd_ff, cmd_in;
   logic [KEY_W-1:0]        op_key_ff, op_key_in;
   logic [ITEM_W-1:0]       op_item_ff, op_item_in;
   logic [KEY_W-1:0]        rm_key_ff, rm_key_in;
   logic [ITEM_W-1:0]       rm_item_ff, rm_item_in;
   logic [KEY_W-1:0]        start_key_ff;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]     rsp_status_ff, rsp_status_in;
   logic [KEY_W-1:0]        rsp_key_ff, rsp_key_in;
   logic [ITEM_W-1:0]       rsp_item_ff, rsp_item_in;
   logic [COUNT_OUT_W-1:0]  rsp_count_ff, rsp_count_in;

   logic                    list_full;
   logic                    list_empty;
   logic [AW-1:0]           last_addr;
   logic [KEY_W-1:0]        rd_key;
   logic [ITEM_W-1:0]       rd_item;

   assign list_full  = (count_ff == CW'(CAPACITY));
   assign list_empty = (count_ff == '0);
   assign last_addr  = AW'(count_ff - CW'(1));
   assign rd_key     = rd_data_ff[EW-1:ITEM_W];
   assign rd_item    = rd_data_ff[ITEM_W-1:0];

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      pos_in        = pos_ff;
      idx_in        = idx_ff;
      cmd_in        = cmd_ff;
      op_key_in     = op_key_ff;
      op_item_in    = op_item_ff;
      rm_key_in     = rm_key_ff;
      rm_item_in    = rm_item_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = ST_OK;
      rsp_key_in    = '0;
      rsp_item_in   = '0;
      rd_addr       = '0;
      wr_en         = 1'b0;
      wr_addr       = '0;
      wr_data       = '0;
      pop           = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               pop        = 1'b1;
               cmd_in     = q_req.cmd;
               op_key_in  = q_req.key;
               op_item_in = q_req.item;
               pos_in     = '0;
               unique case (q_req.cmd)
                  CMD_PREPEND, CMD_APPEND: begin
                     if (list_full) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = ST_FULL;
                     end else if (list_empty) begin
                        wr_en         = 1'b1;
                        wr_data       = {start_key_ff, q_req.item};
                        count_in      = count_ff + CW'(1);
                        rsp_valid_in  = 1'b1;
                        rsp_key_in    = start_key_ff;
                     end else begin
                        rd_addr  = (q_req.cmd == CMD_PREPEND) ? '0 : last_addr;
                        state_in = S_HEAD;
                     end
                  end
                  CMD_REM_HEAD: begin
                     if (list_empty) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = ST_MISS;
                     end else begin
                        state_in = S_HEAD;
                     end
                  end
                  CMD_INSERT: begin
                     if (list_full) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = ST_FULL;
                     end else if (list_empty) begin
                        state_in = S_PUT;
                     end else begin
                        state_in = S_SCAN;
                     end
                  end
                  CMD_REM_KEY: begin
                     if (list_empty) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = ST_MISS;
                     end else begin
                        state_in = S_SCAN;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         S_HEAD: begin
            unique case (cmd_ff)
               CMD_PREPEND: begin
                  op_key_in = rd_key - KEY_W'(1);
                  idx_in    = last_addr;
                  rd_addr   = last_addr;
                  state_in  = S_UP;
               end
               CMD_APPEND: begin
                  op_key_in = rd_key + KEY_W'(1);
                  pos_in    = count_ff;
                  state_in  = S_PUT;
               end
               default: begin
                  rm_key_in  = rd_key;
                  rm_item_in = rd_item;
                  if (count_ff == CW'(1)) begin
                     state_in = S_REM;
                  end else begin
                     idx_in   = '0;
                     rd_addr  = AW'(1);
                     state_in = S_DN;
                  end
               end
            endcase
         end
         S_SCAN: begin
            if (cmd_ff == CMD_INSERT) begin
               if (key_less(rd_key, op_key_ff)) begin
                  if (pos_ff + CW'(1) == count_ff) begin
                     pos_in   = count_ff;
                     state_in = S_PUT;
                  end else begin
                     pos_in  = pos_ff + CW'(1);
                     rd_addr = AW'(pos_ff + CW'(1));
                  end
               end else begin
                  idx_in   = last_addr;
                  rd_addr  = last_addr;
                  state_in = S_UP;
               end
            end else begin
               if (rd_key == op_key_ff) begin
                  rm_key_in  = rd_key;
                  rm_item_in = rd_item;
                  if (pos_ff + CW'(1) == count_ff) begin
                     state_in = S_REM;
                  end else begin
                     idx_in   = AW'(pos_ff);
                     rd_addr  = AW'(pos_ff + CW'(1));
                     state_in = S_DN;
                  end
               end else if (pos_ff + CW'(1) == count_ff) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = ST_MISS;
                  state_in      = S_IDLE;
               end else begin
                  pos_in  = pos_ff + CW'(1);
                  rd_addr = AW'(pos_ff + CW'(1));
               end
            end
         end
         S_UP: begin
            wr_en   = 1'b1;
            wr_addr = idx_ff + AW'(1);
            wr_data = rd_data_ff;
            if (idx_ff == AW'(pos_ff)) begin
               state_in = S_PUT;
            end else begin
               idx_in  = idx_ff - AW'(1);
               rd_addr = idx_ff - AW'(1);
            end
         end
         S_PUT: begin
            wr_en        = 1'b1;
            wr_addr      = AW'(pos_ff);
            wr_data      = {op_key_ff, op_item_ff};
            count_in     = count_ff + CW'(1);
            rsp_valid_in = 1'b1;
            rsp_key_in   = op_key_ff;
            state_in     = S_IDLE;
         end
         S_DN: begin
            wr_en   = 1'b1;
            wr_addr = idx_ff;
            wr_data = rd_data_ff;
            if (CW'(idx_ff) + CW'(2) == count_ff) begin
               state_in = S_REM;
            end else begin
               idx_in  = idx_ff + AW'(1);
               rd_addr = idx_ff + AW'(2);
            end
         end
         S_REM: begin
            count_in     = count_ff - CW'(1);
            rsp_valid_in = 1'b1;
            rsp_key_in   = rm_key_ff;
            rsp_item_in  = rm_item_ff;
            state_in     = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      rsp_count_in = COUNT_OUT_W'(count_in);
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= entry_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         start_key_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            start_key_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      pos_ff        <= pos_in;
      idx_ff        <= idx_in;
      cmd_ff        <= cmd_in;
      op_key_ff     <= op_key_in;
      op_item_ff    <= op_item_in;
      rm_key_ff     <= rm_key_in;
      rm_item_ff    <= rm_item_in;
      rsp_status_ff <= rsp_status_in;
      rsp_key_ff    <= rsp_key_in;
      rsp_item_ff   <= rsp_item_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_key_out   = rsp_key_ff;
   assign rsp_item_out  = rsp_item_ff;
   assign rsp_count_out = rsp_count_ff;

endmodule

// File: rtl/core/sorted_key_priority_list_unit.sv
// Top level of the sorted key priority list: front end, request queue and list engine.
// With an idle engine, refusals, misses on an empty list and undefined codes are answered from
// the idle state; an insert into an empty list goes via S_PUT, a non-empty append via S_HEAD
// and S_PUT, and the operations that shift or scan walk the entry memory one entry per cycle.
// One request runs at a time; start is taken while the queue has room; results never stall.
// Synchronous active-high reset empties the list and clears the start key; no clearing pass.
module sorted_key_priority_list_unit
   import skpl_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEFAULT
)
(
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  logic signed [KEY_W-1:0]        csr_wdata,
   input  logic                           start,
   output logic                           busy,
   input  logic [OP_W-1:0]                req_op,
   input  logic signed [KEY_W-1:0]        req_key_in,
   input  logic [ITEM_W-1:0]              req_item_in,
   output logic                           rsp_valid,
   output logic [STATUS_W-1:0]            rsp_status,
   output logic signed [KEY_W-1:0]        rsp_key_out,
   output logic [ITEM_W-1:0]              rsp_item_out,
   output logic [COUNT_OUT_W-1:0]         rsp_count_out
);

   logic      q_full;
   logic      push;
   req_type   push_req;
   logic      q_valid;
   req_type   q_req;
   logic      pop;

   skpl_front u_front (
      .start       (start),
      .req_op      (req_op),
      .req_key_in  (req_key_in),
      .req_item_in (req_item_in),
      .q_full      (q_full),
      .busy        (busy),
      .push        (push),
      .push_req    (push_req)
   );

   skpl_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_req (push_req),
      .pop      (pop),
      .q_full   (q_full),
      .q_valid  (q_valid),
      .q_req    (q_req)
   );

   skpl_back #(
      .CAPACITY (CAPACITY)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .csr_we        (csr_we),
      .csr_wdata     (csr_wdata),
      .q_valid       (q_valid),
      .q_req         (q_req),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_status    (rsp_status),
      .rsp_key_out   (rsp_key_out),
      .rsp_item_out  (rsp_item_out),
      .rsp_count_out (rsp_count_out)
   );

   a_pop_has_entry: assert property (@(posedge clock) disable iff (reset)
      pop |-> q_valid)
      else $error("engine took a request from an empty queue");

   a_accept_queued: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && !reset) |=> q_valid)
      else $error("accepted request did not reach the queue");

   a_full_at_capacity: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_FULL) |-> rsp_count_out == COUNT_OUT_W'(CAPACITY))
      else $error("insert refused while the list had room");

   a_fail_zero_payload: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == ST_FULL || rsp_status == ST_MISS))
         |-> (rsp_key_out == '0 && rsp_item_out == '0))
      else $error("failed request returned a nonzero key or item");

endmodule
